// ===== rtl/core/rfce_pkg.sv =====
// ----------------------------------------------------------------------------
// rfce_pkg: light command frame encoder shared definitions
// Frame record type, scramble tables and byte-level helper functions.
// ----------------------------------------------------------------------------
package rfce_pkg;

    localparam int FRAME_LEN   = 10;  // length byte plus nine payload bytes
    localparam int TOTAL_BYTES = 12;  // frame bytes plus two CRC bytes
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  LEN_BYTE      = 8'h09;
    localparam logic [7:0]  REQ_RESET     = 8'h45;
    localparam logic [7:0]  JUMP_LOW      = 8'h54;
    localparam logic [7:0]  JUMP_HIGH     = 8'hD3;
    localparam logic [7:0]  JUMP_ADD      = 8'h80;
    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [7:0]  LEN_BYTE_REV  = 8'h90;

    localparam int          ADDR_W           = 3;
    localparam logic [0:0]  REG_REQUEST_TYPE = 1'b0;

    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

    // offset table, row then key[1:0]
    function automatic logic [7:0] offset_entry(input logic [2:0] row, input logic [1:0] col);
        logic [7:0] v;
        begin
            v = 8'h00;
            case ({row, col})
                5'd0:  v = 8'h45;  5'd1:  v = 8'h1F;  5'd2:  v = 8'h14;  5'd3:  v = 8'h5C;
                5'd4:  v = 8'h2B;  5'd5:  v = 8'hC9;  5'd6:  v = 8'hE3;  5'd7:  v = 8'h11;
                5'd8:  v = 8'h6D;  5'd9:  v = 8'h5F;  5'd10: v = 8'h8A;  5'd11: v = 8'h2B;
                5'd12: v = 8'hAF;  5'd13: v = 8'h03;  5'd14: v = 8'h1D;  5'd15: v = 8'hF3;
                5'd16: v = 8'h1A;  5'd17: v = 8'hE2;  5'd18: v = 8'hF0;  5'd19: v = 8'hD1;
                5'd20: v = 8'h04;  5'd21: v = 8'hD8;  5'd22: v = 8'h71;  5'd23: v = 8'h42;
                5'd24: v = 8'hAF;  5'd25: v = 8'h04;  5'd26: v = 8'hDD;  5'd27: v = 8'h07;
                5'd28: v = 8'h61;  5'd29: v = 8'h13;  5'd30: v = 8'h38;  5'd31: v = 8'h64;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] xor_byte(input logic [7:0] key);
        logic [3:0] lo;
        logic [3:0] hi;
        logic [2:0] x;
        logic [3:0] top;
        logic [3:0] bot;
        begin
            lo  = key[3:0];
            hi  = key[7:4];
            x   = 3'(hi + 4'((lo >= 4'd4) ? 1 : 0) + 4'd6);
            top = (4'd4 + {1'b0, x}) ^ 4'd1;
            bot = (lo + 4'd4) ^ 4'd2;
            return {top, bot};
        end
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        begin
            for (int i = 0; i < 8; i++) begin
                r[i] = v[7-i];
            end
            return r;
        end
    endfunction

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] s;
        begin
            s = crc;
            for (int j = 0; j < 8; j++) begin
                if (b[j] ^ s[0]) begin
                    s = (s >> 1) ^ CRC_POLY;
                end else begin
                    s = s >> 1;
                end
            end
            return s;
        end
    endfunction

endpackage

// ===== rtl/core/rfce_front.sv =====
// ----------------------------------------------------------------------------
// rfce_front: command intake and payload scrambler
// Accepts a command, builds the ten frame bytes with the seven payload bytes
// scrambled, and writes the frame record into the queue.
// ----------------------------------------------------------------------------
module rfce_front (
    input  logic                i_push,
    input  logic                i_q_full,
    input  logic [7:0]          i_key_byte,
    input  logic [15:0]         i_device_id,
    input  logic [7:0]          i_group,
    input  logic [7:0]          i_command,
    input  logic [7:0]          i_argument,
    input  logic [7:0]          i_request_type,
    input  logic [7:0]          i_seq_count,
    output logic                o_q_write,
    output rfce_pkg::t_frame    o_frame
);

    logic [6:0][7:0] plain;
    logic [7:0]      xk;
    logic            jump;
    logic [7:0]      sum;
    logic [7:0]      check;

    assign o_q_write = i_push && !i_q_full;

    always_comb begin
        plain[0] = i_request_type;
        plain[1] = i_device_id[15:8];
        plain[2] = i_device_id[7:0];
        plain[3] = i_command;
        plain[4] = i_argument;
        plain[5] = i_seq_count;
        plain[6] = i_group;

        xk   = rfce_pkg::xor_byte(i_key_byte);
        jump = (i_key_byte >= rfce_pkg::JUMP_LOW) && (i_key_byte <= rfce_pkg::JUMP_HIGH);

        sum = xk;
        for (int i = 0; i < 7; i++) begin
            sum = sum + plain[i];
        end
        check = ((sum + 8'd2) ^ xk) + rfce_pkg::offset_entry(3'd7, i_key_byte[1:0]);

        o_frame[0] = rfce_pkg::LEN_BYTE;
        o_frame[1] = i_key_byte;
        for (int i = 0; i < 7; i++) begin
            o_frame[i+2] = (plain[i] ^ xk) + rfce_pkg::offset_entry(3'(i), i_key_byte[1:0])
                           + (jump ? rfce_pkg::JUMP_ADD : 8'h00);
        end
        o_frame[9] = check;
    end

endmodule

// ===== rtl/core/rfce_queue.sv =====
// ----------------------------------------------------------------------------
// rfce_queue: frame record queue
// Short register queue between the scrambler and the serializer.
// ----------------------------------------------------------------------------
module rfce_queue #(
    parameter int DEPTH = rfce_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_write,
    input  rfce_pkg::t_frame    i_wr_data,
    input  logic                i_read,
    output rfce_pkg::t_frame    o_rd_data,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfce_pkg::t_frame  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_write) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_read) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_write && !i_read) begin
                r_count <= r_count + 1'b1;
            end else if (!i_write && i_read) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/rfce_back.sv =====
// ----------------------------------------------------------------------------
// rfce_back: frame serializer with CRC
// Sends the frame bytes one per cycle while the output is not stalled, folds
// each into the CRC, then sends the CRC low and high bytes, all bit-reversed.
// ----------------------------------------------------------------------------
module rfce_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  rfce_pkg::t_frame    i_q_frame,
    output logic                o_q_read,
    input  logic                i_pop,
    output logic                o_valid,
    output logic [7:0]          o_tx_byte,
    output logic                o_last_byte
);

    localparam logic [3:0] LAST_IDX = 4'(rfce_pkg::TOTAL_BYTES - 1);
    localparam logic [3:0] CRC_LO   = 4'(rfce_pkg::FRAME_LEN);

    logic               r_active;
    logic [3:0]         r_idx;
    rfce_pkg::t_frame   r_frame;
    logic [15:0]        r_crc;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic               adv;
    logic               load;
    logic [7:0]         cur_byte;

    assign adv      = r_active && (!r_out_valid || i_pop);
    assign load     = !i_q_empty && (!r_active || (adv && r_idx == LAST_IDX));
    assign o_q_read = load;

    always_comb begin
        if (r_idx < CRC_LO) begin
            cur_byte = r_frame[r_idx];
        end else if (r_idx == CRC_LO) begin
            cur_byte = r_crc[7:0];
        end else begin
            cur_byte = r_crc[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= i_q_frame;
        end
        if (load) begin
            r_crc <= '0;
        end else if (adv && r_idx < CRC_LO) begin
            r_crc <= rfce_pkg::crc_byte(r_crc, cur_byte);
        end
        if (adv) begin
            r_out_byte <= rfce_pkg::rev8(cur_byte);
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (adv) begin
                // drop out of the frame after the CRC high byte
                if (r_idx == LAST_IDX) begin
                    r_active <= 1'b0;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

// ===== rtl/core/rf_light_command_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// rf_light_command_frame_encoder_top: light command radio frame encoder
//
//   channel   ports                                      direction
//   command   push/full, i_key_byte..i_argument          in
//   frame     empty/pop, o_tx_byte, o_last_byte          out
//   config    psel/penable/pwrite/paddr/pwdata/prdata    APB slave
//
// Each command yields twelve bytes, one per cycle when pop is held high; the
// byte-wide serializer starts a frame only after the last one's final byte;
// a command passes the queue, frame and output byte registers on its way out.
// The scrambler finishes in the accept cycle; a two-entry frame queue lets
// commands be taken while the serializer is busy or the output stalls.
// Reset is synchronous; it clears the queue, serializer, sequence count and
// sets request_type to 0x45.
// ----------------------------------------------------------------------------
module rf_light_command_frame_encoder_top #(
    parameter int QUEUE_DEPTH = rfce_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_key_byte,
    input  logic [15:0]                 i_device_id,
    input  logic [7:0]                  i_group,
    input  logic [7:0]                  i_command,
    input  logic [7:0]                  i_argument,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_tx_byte,
    output logic                        o_last_byte,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic               req_sel;
    logic [7:0]         r_req_type;
    logic [7:0]         r_seq_count;
    logic               cfg_write;
    logic               q_write;
    logic               q_read;
    logic               q_full;
    logic               q_empty;
    logic               out_valid;
    rfce_pkg::t_frame   wr_frame;
    rfce_pkg::t_frame   rd_frame;

    assign req_sel   = (paddr[2] == rfce_pkg::REG_REQUEST_TYPE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = req_sel ? {24'h0, r_req_type} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_type  <= rfce_pkg::REQ_RESET;
            r_seq_count <= '0;
        end else begin
            if (cfg_write && req_sel) begin
                r_req_type <= pwdata[7:0];
            end
            // advance once per accepted command
            if (q_write) begin
                r_seq_count <= r_seq_count + 1'b1;
            end
        end
    end

    rfce_front u_front (
        .i_push         (push),
        .i_q_full       (q_full),
        .i_key_byte     (i_key_byte),
        .i_device_id    (i_device_id),
        .i_group        (i_group),
        .i_command      (i_command),
        .i_argument     (i_argument),
        .i_request_type (r_req_type),
        .i_seq_count    (r_seq_count),
        .o_q_write      (q_write),
        .o_frame        (wr_frame)
    );

    rfce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_write   (q_write),
        .i_wr_data (wr_frame),
        .i_read    (q_read),
        .o_rd_data (rd_frame),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    rfce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_frame   (rd_frame),
        .o_q_read    (q_read),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

    assign full  = q_full;
    assign empty = !out_valid;

    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> (r_seq_count == $past(r_seq_count) + 8'd1))
        else $error("sequence count did not advance on an accepted transaction");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_byte) |=> (empty || o_tx_byte == rfce_pkg::LEN_BYTE_REV))
        else $error("frame after a last byte does not open with the length byte");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[2] == rfce_pkg::REG_REQUEST_TYPE)
        |=> (r_req_type == $past(pwdata[7:0])))
        else $error("request type register missed a write");

endmodule
